// ===== rtl/core/reweighted_soft_threshold_unit_defines.svh =====
// Assertion macros for the reweighted soft-threshold unit checker.
// Expect signals clk and rst in the scope of use.
`ifndef REWEIGHTED_SOFT_THRESHOLD_UNIT_DEFINES_SVH
`define REWEIGHTED_SOFT_THRESHOLD_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define RSTU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rstu checker: implication failed");

// next-cycle implication, off during reset
`define RSTU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rstu checker: next-cycle implication failed");

// condition that must hold in the cycle after reset
`define RSTU_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("rstu checker: reset condition failed");

`endif

// ===== rtl/core/rstu_pkg.sv =====
// Package for the reweighted soft-threshold unit: constants, register codes,
// fixed-point helpers. No dependencies.
package rstu_pkg;

  localparam int unsigned MAX_PASSES_DEF = 8;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned VAL_W = 31;   // width of non-negative intermediates
  localparam int unsigned COEFF_W = 32;
  localparam int unsigned DIV_Y_W = 32;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  localparam logic [30:0] TAU_RST   = 31'd65536;
  localparam logic [30:0] KAPPA_RST = 31'd131072;
  localparam logic [30:0] BETA_RST  = 31'd3277;
  localparam logic [30:0] NORM_RST  = 31'd0;
  localparam logic [3:0]  PASS_RST  = 4'd2;

  typedef enum logic [2:0] {
    REG_TAU   = 3'd0,
    REG_KAPPA = 3'd1,
    REG_BETA  = 3'd2,
    REG_NORM  = 3'd3,
    REG_PASSES = 3'd4
  } reg_index_t;

  // (product >> frac) saturated to VAL_MAX
  function automatic logic [VAL_W-1:0] fx_scale(logic [63:0] p, int unsigned frac);
    logic [63:0] s;
    s = p >> frac;
    return (s > 64'(VAL_MAX)) ? VAL_MAX : s[VAL_W-1:0];
  endfunction

endpackage

// ===== rtl/core/rstu_div.sv =====
// Pipelined saturating fixed-point divider, one quotient bit per stage.
// Depends on rstu_pkg.
module rstu_div #(
  parameter int unsigned FRAC_BITS = rstu_pkg::FRAC_BITS_DEF,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rstu_pkg::VAL_W-1:0]  x,
  input  logic [rstu_pkg::DIV_Y_W-1:0] y,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [rstu_pkg::VAL_W-1:0]  q,
  output logic [SIDE_W-1:0]           side_out
);

  localparam int unsigned QW = rstu_pkg::VAL_W;
  localparam int unsigned YW = rstu_pkg::DIV_Y_W;

  logic          v    [0:QW];
  logic          sat  [0:QW];
  logic [YW-1:0] rem  [0:QW];
  logic [QW-1:0] ql   [0:QW];
  logic [QW-1:0] dl   [0:QW];
  logic [YW-1:0] yv   [0:QW];
  logic [SIDE_W-1:0] sd [0:QW];

  logic [63:0] dext;
  logic [63:0] ysh;

  assign dext = 64'(x) << FRAC_BITS;
  assign ysh  = 64'(y) << QW;

  // quotient above VAL_MAX (or zero divisor) is caught up front
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      sat[0] <= (dext >= ysh);
      rem[0] <= YW'(dext >> QW);
      ql[0]  <= '0;
      dl[0]  <= dext[QW-1:0];
      yv[0]  <= y;
      sd[0]  <= side_in;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [YW:0] r2;
    logic        ge;
    assign r2 = {rem[s], dl[s][QW-1]};
    assign ge = (r2 >= {1'b0, yv[s]});
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        sat[s+1] <= sat[s];
        rem[s+1] <= ge ? YW'(r2 - {1'b0, yv[s]}) : r2[YW-1:0];
        ql[s+1]  <= {ql[s][QW-2:0], ge};
        dl[s+1]  <= dl[s] << 1;
        yv[s+1]  <= yv[s];
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign out_valid = v[QW];
  assign q         = sat[QW] ? rstu_pkg::VAL_MAX : ql[QW];
  assign side_out  = sd[QW];

endmodule

// ===== rtl/core/reweighted_soft_threshold_unit.sv =====
// Reweighted soft-threshold unit, top level.
// Depends on rstu_pkg and rstu_div.
//
// Usage:
//   Input channel in_valid/in_stall carries coeff_in (Q16.16 signed); the
//   output channel out_valid/out_stall carries coeff_out. A transaction
//   completes on a rising edge with valid high and stall low.
//   Configuration: cfg_write with cfg_index (0 tau, 1 kappa, 2 beta,
//   3 norm_term, 4 passes) and cfg_data; other indexes are ignored. Write
//   only while the unit is empty.
//   Throughput: one coefficient per cycle while in_stall is low. Each pass
//   but the last is a shrink stage and a 32-stage divider (entry stage plus
//   31 one-bit steps) for the next threshold, the last only a shrink stage;
//   the first threshold uses two multiplier stages and a divider. The path
//   to out_valid is the same whatever the passes setting.
//   Stall: while a result waits in the output register the pipeline keeps
//   moving; the next result to reach the end goes to a skid entry, then the
//   whole pipeline freezes and in_stall is raised, nothing is dropped.
//   Reset: synchronous rst clears all valid bits and loads default registers.
module reweighted_soft_threshold_unit #(
  parameter int unsigned MAX_PASSES = rstu_pkg::MAX_PASSES_DEF,
  parameter int unsigned FRAC_BITS  = rstu_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  coeff_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  coeff_out
);

  localparam int unsigned VW = rstu_pkg::VAL_W;
  localparam int unsigned CW = rstu_pkg::COEFF_W;
  localparam int unsigned NW = $clog2(MAX_PASSES + 1);
  localparam int unsigned SW = CW + NW;

  logic [30:0] tau;
  logic [30:0] kappa;
  logic [30:0] beta;
  logic [30:0] norm_term;
  logic [3:0]  passes;

  always_ff @(posedge clk) begin
    if (rst) begin
      tau       <= rstu_pkg::TAU_RST;
      kappa     <= rstu_pkg::KAPPA_RST;
      beta      <= rstu_pkg::BETA_RST;
      norm_term <= rstu_pkg::NORM_RST;
      passes    <= rstu_pkg::PASS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rstu_pkg::REG_TAU:    tau       <= cfg_data;
        rstu_pkg::REG_KAPPA:  kappa     <= cfg_data;
        rstu_pkg::REG_BETA:   beta      <= cfg_data;
        rstu_pkg::REG_NORM:   norm_term <= cfg_data;
        rstu_pkg::REG_PASSES: passes    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // kappa+1 and tau*(kappa+1), static between config writes
  logic [31:0]   kp1;
  logic [VW-1:0] num;
  always_ff @(posedge clk) begin
    kp1 <= 32'(kappa) + (32'd1 << FRAC_BITS);
    num <= rstu_pkg::fx_scale(64'(tau) * 64'(kp1), FRAC_BITS);
  end

  logic skid_valid;
  logic en;
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  logic [NW-1:0] n_in;
  always_comb begin
    if (int'(passes) > int'(MAX_PASSES)) n_in = NW'(MAX_PASSES);
    else n_in = NW'(passes);
  end

  // first threshold: two multiply stages
  logic                 v1, v2;
  logic signed [CW-1:0] a1, a2;
  logic [NW-1:0]        n1, n2;
  logic [VW-1:0]        m1, m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
    if (en) begin
      a1 <= coeff_in;
      n1 <= n_in;
      m1 <= rstu_pkg::fx_scale(64'(tau) * 64'(norm_term), FRAC_BITS);
      a2 <= a1;
      n2 <= n1;
      m2 <= rstu_pkg::fx_scale(64'(m1) * 64'(kp1), FRAC_BITS);
    end
  end

  logic                 pv [0:MAX_PASSES];
  logic signed [CW-1:0] pa [0:MAX_PASSES];
  logic [NW-1:0]        pn [0:MAX_PASSES];
  logic [VW-1:0]        pt [0:MAX_PASSES-1];
  logic [SW-1:0]        side0;

  rstu_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_div0 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2), .x(m2), .y(32'(beta)), .side_in({a2, n2}),
    .out_valid(pv[0]), .q(pt[0]), .side_out(side0)
  );
  assign pa[0] = side0[SW-1:NW];
  assign pn[0] = side0[NW-1:0];

  for (genvar k = 0; k < MAX_PASSES; k++) begin : g_pass
    logic signed [CW-1:0] ts;
    logic signed [CW-1:0] na;
    logic [CW-1:0]        mag;
    logic                 sv;
    logic signed [CW-1:0] sa;
    logic [NW-1:0]        sn;
    logic [31:0]          sy;

    assign ts = signed'({1'b0, pt[k]});
    always_comb begin
      if (NW'(k) >= pn[k]) na = pa[k];
      else if (pa[k] > ts) na = pa[k] - ts;
      else if (pa[k] < -ts) na = pa[k] + ts;
      else na = '0;
      mag = na[CW-1] ? CW'(-na) : CW'(na);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv <= 1'b0;
      end else if (en) begin
        sv <= pv[k];
      end
      if (en) begin
        sa <= na;
        sn <= pn[k];
        sy <= mag + 32'(beta);
      end
    end

    if (k < MAX_PASSES - 1) begin : g_div
      logic [SW-1:0] so;
      rstu_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_div (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(sv), .x(num), .y(sy), .side_in({sa, sn}),
        .out_valid(pv[k+1]), .q(pt[k+1]), .side_out(so)
      );
      assign pa[k+1] = so[SW-1:NW];
      assign pn[k+1] = so[NW-1:0];
    end else begin : g_last
      assign pv[k+1] = sv;
      assign pa[k+1] = sa;
      assign pn[k+1] = sn;
    end
  end

  // output register plus skid entry
  logic signed [CW-1:0] skid_data;
  logic                 out_take;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= pv[MAX_PASSES];
    end else if (pv[MAX_PASSES]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) coeff_out <= skid_data;
    end else if (!out_valid || out_take) begin
      coeff_out <= pa[MAX_PASSES];
    end else begin
      skid_data <= pa[MAX_PASSES];
    end
  end

endmodule

// ===== rtl/core/rstu_checker.sv =====
// Port-level checker for the reweighted soft-threshold unit, with its bind.
// Depends on reweighted_soft_threshold_unit_defines.svh.
`include "reweighted_soft_threshold_unit_defines.svh"

module rstu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] coeff_out
);

  `RSTU_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `RSTU_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(coeff_out))
  `RSTU_ASSERT_IMP(a_stall_full, in_stall, out_valid)
  `RSTU_ASSERT_IMP(a_stall_cause, $rose(in_stall), $past(out_valid) && $past(out_stall))
  `RSTU_ASSERT_RST(a_reset_empty, !out_valid && !in_stall)

endmodule

bind reweighted_soft_threshold_unit rstu_checker u_rstu_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .coeff_out(coeff_out)
);

// ===== dv/reweighted_soft_threshold_unit_tb.sv =====
// Testbench for reweighted_soft_threshold_unit: random and directed coefficients,
// predicted by a local fixed-point model and checked in order by a scoreboard.
// Depends on rstu_pkg and the unit's RTL.
module reweighted_soft_threshold_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY = 35 + 33 * (rstu_pkg::MAX_PASSES_DEF - 1);
  localparam int unsigned WATCHDOG = 20000;

  class shrink_scoreboard;
    logic [63:0] tau_r, kappa_r, beta_r, norm_r;
    logic [3:0] passes_r;
    logic signed [31:0] pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      tau_r = 64'(rstu_pkg::TAU_RST); kappa_r = 64'(rstu_pkg::KAPPA_RST);
      beta_r = 64'(rstu_pkg::BETA_RST);
      norm_r = 64'(rstu_pkg::NORM_RST); passes_r = rstu_pkg::PASS_RST;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(rstu_pkg::reg_index_t idx, logic [30:0] v);
      case (idx)
        rstu_pkg::REG_TAU: tau_r = 64'(v);
        rstu_pkg::REG_KAPPA: kappa_r = 64'(v);
        rstu_pkg::REG_BETA: beta_r = 64'(v);
        rstu_pkg::REG_NORM: norm_r = 64'(v);
        rstu_pkg::REG_PASSES: passes_r = v[3:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] clip(logic [63:0] x);
      return (x > 64'h7fffffff) ? 64'h7fffffff : x;
    endfunction

    function logic [63:0] qmul(logic [63:0] x, logic [63:0] y);
      return clip((x * y) >> rstu_pkg::FRAC_BITS_DEF);
    endfunction

    function logic [63:0] qdiv(logic [63:0] x, logic [63:0] y);
      if (y == 0) return 64'h7fffffff;
      return clip((x << rstu_pkg::FRAC_BITS_DEF) / y);
    endfunction

    function logic signed [31:0] shrink(logic signed [31:0] c);
      logic signed [63:0] a, ts;
      logic [63:0] kp1, t, num, mag;
      int n;
      a = c;
      kp1 = kappa_r + (64'd1 << rstu_pkg::FRAC_BITS_DEF);
      n = (int'(passes_r) > int'(rstu_pkg::MAX_PASSES_DEF)) ?
          int'(rstu_pkg::MAX_PASSES_DEF) : int'(passes_r);
      t = qdiv(qmul(qmul(tau_r, norm_r), kp1), beta_r);
      num = qmul(tau_r, kp1);
      for (int k = 0; k < n; k++) begin
        ts = t;
        if (a > ts) a = a - ts;
        else if (a < -ts) a = a + ts;
        else a = 0;
        mag = (a < 0) ? -a : a;
        t = qdiv(num, mag + beta_r);
      end
      return a[31:0];
    endfunction

    function void note_input(logic signed [31:0] c);
      pending.push_back(shrink(c));
    endfunction

    function void check_result(logic signed [31:0] got);
      logic signed [31:0] exp_v;
      if (pending.size() == 0) begin
        $error("coeff_out: unexpected result %0d", got);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      checked++;
      if (got !== exp_v) begin
        $error("coeff_out: expected %0d actual %0d", exp_v, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] coeff_in = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] coeff_out;

  shrink_scoreboard sb = new();
  bit calm = 0;
  bit hold_off = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;

  always #5 clk = ~clk;

  reweighted_soft_threshold_unit DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .coeff_in,
    .out_valid, .out_stall, .coeff_out
  );

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(coeff_out);
    if (!rst && ((out_valid && !out_stall) || (in_valid && !in_stall)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall process
  initial begin
    int unsigned n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (600) @(posedge clk);
        out_stall <= 0;
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1;
        repeat (n - 1) @(posedge clk);
        @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic write_reg(rstu_pkg::reg_index_t idx, logic [30:0] v);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send(logic signed [31:0] c);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    coeff_in <= c;
    do @(posedge clk); while (in_stall);
    sb.note_input(c);
    sent++;
  endtask

  task automatic idle_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coeff();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 20'hfffff)) - 32'sh80000;
      2: return $signed($urandom_range(0, 24'hffffff)) - 32'sh800000;
      3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      default: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 99)
                                           : 32'sh80000000 + $urandom_range(0, 99);
    endcase
  endfunction

  function automatic logic [30:0] rand_param();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 31'h7fffffff));
      1: return 31'($urandom_range(0, 31'h3ffff));
      2: return 31'($urandom_range(31'h7fff0000, 31'h7fffffff));
      default: return $urandom_range(0, 1) ? 31'd0 : 31'h7fffffff;
    endcase
  endfunction

  task automatic run_block(int unsigned count);
    for (int i = 0; i < count; i++) send(rand_coeff());
    idle_input();
  endtask

  initial begin
    logic signed [31:0] edge_vals[8];
    edge_vals = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, 32'sh10000, -32'sh10000, 3277};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults, then norm_term nonzero
    foreach (edge_vals[i]) send(edge_vals[i]);
    idle_input();
    drain();
    write_reg(rstu_pkg::REG_NORM, 31'h10000);
    foreach (edge_vals[i]) send(edge_vals[i]);
    idle_input();
    drain();
    // zero passes, too many passes, zero beta, then saturating tau, kappa and norm_term
    write_reg(rstu_pkg::REG_PASSES, 31'd0);
    send(32'sh12345678); send(32'sh80000000);
    idle_input(); drain();
    write_reg(rstu_pkg::REG_PASSES, 31'd15);
    send(32'sh7fffffff); send(-32'sh20000);
    idle_input(); drain();
    write_reg(rstu_pkg::REG_BETA, 31'd0);
    send(0); send(32'sh40000); send(32'sh80000000);
    idle_input(); drain();
    write_reg(rstu_pkg::REG_TAU, 31'h7fffffff);
    write_reg(rstu_pkg::REG_KAPPA, 31'h7fffffff);
    write_reg(rstu_pkg::REG_NORM, 31'h7fffffff);
    send(32'sh7fffffff); send(32'sh80000000);
    idle_input(); drain();
    // unknown index is ignored by the unit
    @(posedge clk);
    cfg_write <= 1; cfg_index <= 3'd7; cfg_data <= 31'h1234;
    @(posedge clk);
    cfg_write <= 0;

    // long receiver hold-off while inputs keep coming, enough to fill the pipeline
    write_reg(rstu_pkg::REG_TAU, 31'h8000);
    write_reg(rstu_pkg::REG_KAPPA, 31'h10000);
    write_reg(rstu_pkg::REG_BETA, 31'h1000);
    write_reg(rstu_pkg::REG_NORM, 31'h20000);
    write_reg(rstu_pkg::REG_PASSES, 31'd8);
    hold_off = 1;
    run_block(400);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(rstu_pkg::REG_TAU, ($urandom_range(0, 2) == 0) ?
                rand_param() : 31'($urandom_range(0, 31'h40000)));
      write_reg(rstu_pkg::REG_KAPPA, rand_param());
      write_reg(rstu_pkg::REG_BETA, ($urandom_range(0, 5) == 0) ? 31'd0 : rand_param());
      write_reg(rstu_pkg::REG_NORM, ($urandom_range(0, 2) == 0) ?
                rand_param() : 31'($urandom_range(0, 31'h40000)));
      write_reg(rstu_pkg::REG_PASSES, 31'($urandom_range(0, 15)));
      if (ph == 9) calm = 1;
      run_block(100);
      drain();
    end

    $display("Sent %0d coefficients and checked %0d results across random register sets.",
             sent, sb.checked);
    $display("Covered zero, maximal and oversized pass counts, zero beta, saturation, backpressure.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rstu_pkg.sv
rtl/core/rstu_div.sv
rtl/core/reweighted_soft_threshold_unit.sv
rtl/core/rstu_checker.sv
dv/reweighted_soft_threshold_unit_tb.sv
